### rtl/bppg_pkg.sv
// ----------------------------------------------------------------------------
// bppg_pkg
// Shared types, pattern codes and the waves lookup table for the
// background pattern pixel generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bppg_pkg;

  // Field widths
  localparam int unsigned ColorW = 16;
  localparam int unsigned CoordW = 8;
  localparam int unsigned DimW   = 9;
  localparam int unsigned KindW  = 4;
  localparam int unsigned IdxW   = 3;

  // Largest tile dimension used by the gradients; larger values saturate
  localparam int unsigned MaxTileDim = 256;

  // Divider geometry: |diff| * coord fits in QuotW bits, divisor is dim - 1
  localparam int unsigned DivW   = 8;
  localparam int unsigned RemW   = DivW;
  localparam int unsigned QuotW  = ColorW + CoordW;
  localparam int unsigned NumCells = QuotW;

  // Pattern codes
  localparam logic [KindW-1:0] PatSolid       = 4'd0;
  localparam logic [KindW-1:0] PatVertGrad    = 4'd1;
  localparam logic [KindW-1:0] PatHorizGrad   = 4'd2;
  localparam logic [KindW-1:0] PatChecker     = 4'd3;
  localparam logic [KindW-1:0] PatNoise       = 4'd4;
  localparam logic [KindW-1:0] PatDiagonal    = 4'd5;
  localparam logic [KindW-1:0] PatTransparent = 4'd6;
  localparam logic [KindW-1:0] PatWaves       = 4'd7;
  localparam logic [KindW-1:0] PatTriangles   = 4'd8;
  localparam logic [KindW-1:0] PatDots        = 4'd9;

  // Register indexes
  localparam logic [IdxW-1:0] RegKind      = 3'd0;
  localparam logic [IdxW-1:0] RegPrimary   = 3'd1;
  localparam logic [IdxW-1:0] RegSecondary = 3'd2;
  localparam logic [IdxW-1:0] RegWidth     = 3'd3;
  localparam logic [IdxW-1:0] RegHeight    = 3'd4;

  // Reset value of both tile dimensions
  localparam logic [DimW-1:0] DimReset = 9'd32;

  // Configuration registers as seen by the datapath
  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [ColorW-1:0] primary;
    logic [ColorW-1:0] secondary;
    logic [DimW-1:0]   tile_width;
    logic [DimW-1:0]   tile_height;
  } cfg_t;

  // One item as it travels down the divider chain
  typedef struct packed {
    logic [ColorW-1:0] primary;     // gradient base
    logic [ColorW-1:0] flat_color;  // color for non-gradient patterns
    logic              grad;        // take the gradient result
    logic              neg;         // quotient is subtracted from base
    logic              we;          // write flag
    logic [DivW-1:0]   divisor;     // dim - 1
    logic [RemW-1:0]   rem;         // partial remainder
    logic [QuotW-1:0]  acc;         // dividend bits in, quotient bits out
  } item_t;

  // floor(16 + 8 sin(2 pi k / 32))
  function automatic logic [4:0] wave_center(input logic [4:0] k);
    logic [4:0] w;
    begin
      case (k)
        5'd0:  w = 5'd16;  5'd1:  w = 5'd17;  5'd2:  w = 5'd19;  5'd3:  w = 5'd20;
        5'd4:  w = 5'd21;  5'd5:  w = 5'd22;  5'd6:  w = 5'd23;  5'd7:  w = 5'd23;
        5'd8:  w = 5'd24;  5'd9:  w = 5'd23;  5'd10: w = 5'd23;  5'd11: w = 5'd22;
        5'd12: w = 5'd21;  5'd13: w = 5'd20;  5'd14: w = 5'd19;  5'd15: w = 5'd17;
        5'd16: w = 5'd16;  5'd17: w = 5'd14;  5'd18: w = 5'd12;  5'd19: w = 5'd11;
        5'd20: w = 5'd10;  5'd21: w = 5'd9;   5'd22: w = 5'd8;   5'd23: w = 5'd8;
        5'd24: w = 5'd8;   5'd25: w = 5'd8;   5'd26: w = 5'd8;   5'd27: w = 5'd9;
        5'd28: w = 5'd10;  5'd29: w = 5'd11;  5'd30: w = 5'd12;  default: w = 5'd14;
      endcase
      return w;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/bppg_prep.sv
// ----------------------------------------------------------------------------
// bppg_prep
// Entry stage: decodes the pattern, forms the flat color and the gradient
// dividend |S - P| * coord, and registers the item for the divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

module bppg_prep (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire logic [bppg_pkg::CoordW-1:0]   pixel_x_i,
  input  wire logic [bppg_pkg::CoordW-1:0]   pixel_y_i,
  input  wire logic                          random_bit_i,
  input  wire bppg_pkg::cfg_t                cfg_i,
  output logic                               valid_o,
  output bppg_pkg::item_t                    item_o
);

  logic                           valid_q;
  bppg_pkg::item_t                item_d, item_q;

  logic [bppg_pkg::ColorW-1:0]    p, s;
  logic [bppg_pkg::ColorW:0]      diff;
  logic [bppg_pkg::ColorW-1:0]    mag;
  logic                           diff_neg;
  logic [bppg_pkg::DimW-1:0]      dim_raw, dim_c;
  logic [bppg_pkg::CoordW-1:0]    coord;
  logic                           use_grad;
  logic [2:0]                     sum3;
  logic [3:0]                     sum4;
  logic [bppg_pkg::CoordW-1:0]    wave_c, wave_dist;

  assign p = cfg_i.primary;
  assign s = cfg_i.secondary;

  // Signed difference S - P, then its magnitude
  assign diff     = {1'b0, s} - {1'b0, p};
  assign diff_neg = diff[bppg_pkg::ColorW];
  assign mag      = diff_neg ? bppg_pkg::ColorW'(~diff + 1'b1)
                             : diff[bppg_pkg::ColorW-1:0];

  assign use_grad = (cfg_i.kind == bppg_pkg::PatVertGrad) ||
                    (cfg_i.kind == bppg_pkg::PatHorizGrad);
  assign dim_raw  = (cfg_i.kind == bppg_pkg::PatVertGrad) ? cfg_i.tile_height
                                                          : cfg_i.tile_width;
  assign coord    = (cfg_i.kind == bppg_pkg::PatVertGrad) ? pixel_y_i : pixel_x_i;
  assign dim_c    = (dim_raw > bppg_pkg::DimW'(bppg_pkg::MaxTileDim))
                    ? bppg_pkg::DimW'(bppg_pkg::MaxTileDim) : dim_raw;

  assign sum3 = pixel_x_i[2:0] + pixel_y_i[2:0];
  assign sum4 = pixel_x_i[3:0] + pixel_y_i[3:0];

  assign wave_c    = bppg_pkg::CoordW'(bppg_pkg::wave_center(pixel_x_i[4:0]));
  assign wave_dist = (pixel_y_i >= wave_c) ? (pixel_y_i - wave_c) : (wave_c - pixel_y_i);

  always_comb begin
    item_d            = '0;
    item_d.primary    = p;
    item_d.flat_color = p;
    item_d.we         = 1'b1;
    item_d.divisor    = bppg_pkg::DivW'(1);
    item_d.rem        = '0;
    item_d.acc        = '0;
    case (cfg_i.kind)
      bppg_pkg::PatChecker:     item_d.flat_color = (pixel_x_i[2] ^ pixel_y_i[2]) ? s : p;
      bppg_pkg::PatNoise:       item_d.flat_color = random_bit_i ? p : s;
      bppg_pkg::PatDiagonal:    item_d.flat_color = sum3[2] ? s : p;
      bppg_pkg::PatTransparent: begin
        item_d.flat_color = '0;
        item_d.we         = 1'b0;
      end
      bppg_pkg::PatWaves:       item_d.flat_color = (wave_dist <= 8'd2) ? s : p;
      bppg_pkg::PatTriangles:   item_d.flat_color = sum4[3] ? s : p;
      bppg_pkg::PatDots:
        item_d.flat_color = ((pixel_x_i[1:0] == 2'd0) && (pixel_y_i[1:0] == 2'd0)) ? p : s;
      default:                  item_d.flat_color = p;
    endcase
    // A dimension of one or zero leaves the flat primary color
    if (use_grad && (dim_c > bppg_pkg::DimW'(1))) begin
      item_d.grad    = 1'b1;
      item_d.neg     = diff_neg;
      item_d.divisor = bppg_pkg::DivW'(dim_c - bppg_pkg::DimW'(1));
      item_d.acc     = bppg_pkg::QuotW'(mag) * bppg_pkg::QuotW'(coord);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

### rtl/bppg_div_cell.sv
// ----------------------------------------------------------------------------
// bppg_div_cell
// One restoring division step: shifts one dividend bit into the partial
// remainder, subtracts the divisor if it fits, shifts the quotient bit in.
// ----------------------------------------------------------------------------
`default_nettype none

module bppg_div_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire bppg_pkg::item_t  item_i,
  output logic                  valid_o,
  output bppg_pkg::item_t       item_o
);

  logic                          valid_q;
  bppg_pkg::item_t               item_d, item_q;
  logic [bppg_pkg::RemW:0]       trial, trial_sub;
  logic                          fits;

  assign trial     = {item_i.rem, item_i.acc[bppg_pkg::QuotW-1]};
  assign trial_sub = trial - {1'b0, item_i.divisor};
  assign fits      = trial >= {1'b0, item_i.divisor};

  always_comb begin
    item_d     = item_i;
    item_d.rem = fits ? trial_sub[bppg_pkg::RemW-1:0] : trial[bppg_pkg::RemW-1:0];
    item_d.acc = {item_i.acc[bppg_pkg::QuotW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

### rtl/background_pattern_pixel_generator.sv
// Pipeline: entry stage, 24 divider cells, output register; one item per cycle
//   sustained while the output slot is free or being drained.
// The rate is set by the chain of one-bit division cells for the gradients,
//   every item passes through all of them; the chain stalls as a whole.
// Reset: rst_ni (async, active low) clears all valid bits and sets the
//   configuration to solid, colors 0, tile 32 x 32.
// ----------------------------------------------------------------------------
// background_pattern_pixel_generator
// Procedural tile pattern generator: one pixel color and write flag per item.
// ----------------------------------------------------------------------------
`default_nettype none

module background_pattern_pixel_generator (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration write port
  input  wire logic                         cfg_we_i,
  input  wire logic [bppg_pkg::IdxW-1:0]    cfg_index_i,
  input  wire logic [bppg_pkg::ColorW-1:0]  cfg_data_i,
  // input items
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [bppg_pkg::CoordW-1:0]  pixel_x_i,
  input  wire logic [bppg_pkg::CoordW-1:0]  pixel_y_i,
  input  wire logic                         random_bit_i,
  // result items
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [bppg_pkg::ColorW-1:0]       pixel_color_o,
  output logic                              write_enable_o
);

  localparam int unsigned NumCells = bppg_pkg::NumCells;

  // Configuration registers
  bppg_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind        <= bppg_pkg::PatSolid;
      cfg_q.primary     <= '0;
      cfg_q.secondary   <= '0;
      cfg_q.tile_width  <= bppg_pkg::DimReset;
      cfg_q.tile_height <= bppg_pkg::DimReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bppg_pkg::RegKind:      cfg_q.kind        <= cfg_data_i[bppg_pkg::KindW-1:0];
        bppg_pkg::RegPrimary:   cfg_q.primary     <= cfg_data_i;
        bppg_pkg::RegSecondary: cfg_q.secondary   <= cfg_data_i;
        bppg_pkg::RegWidth:     cfg_q.tile_width  <= cfg_data_i[bppg_pkg::DimW-1:0];
        bppg_pkg::RegHeight:    cfg_q.tile_height <= cfg_data_i[bppg_pkg::DimW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Whole pipe moves when the output slot is free or being drained
  logic advance;
  logic out_valid_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // Stage 0: pattern decode and gradient dividend
  logic            chain_valid [NumCells+1];
  bppg_pkg::item_t chain_item  [NumCells+1];

  bppg_prep u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (advance),
    .valid_i      (in_valid_i),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .random_bit_i (random_bit_i),
    .cfg_i        (cfg_q),
    .valid_o      (chain_valid[0]),
    .item_o       (chain_item[0])
  );

  // Stages 1..NumCells: one quotient bit per cell, MSB first
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    bppg_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (chain_valid[g]),
      .item_i  (chain_item[g]),
      .valid_o (chain_valid[g+1]),
      .item_o  (chain_item[g+1])
    );
  end

  // Output stage: apply the signed quotient to the base color, wrap to 16 bits
  bppg_pkg::item_t             last;
  logic [bppg_pkg::ColorW-1:0] quot;
  logic [bppg_pkg::ColorW-1:0] color_d, color_q;
  logic                        we_q;

  assign last  = chain_item[NumCells];
  assign quot  = last.acc[bppg_pkg::ColorW-1:0];

  always_comb begin
    if (last.grad) begin
      color_d = last.neg ? (last.primary - quot) : (last.primary + quot);
    end else begin
      color_d = last.flat_color;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= chain_valid[NumCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      color_q <= color_d;
      we_q    <= last.we;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_color_o  = color_q;
  assign write_enable_o = we_q;

endmodule

`default_nettype wire
